### design/acsr_pkg.sv
package acsr_pkg;

	localparam int WAYS = 8;
	localparam int MEM_WORDS = 128;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_WIDTH = 7;
	localparam int WAY_IDX_W = 3;
	localparam int WAY_CNT_W = 4;
	localparam int STAMP_W = 32;

	localparam logic [1:0] POLICY_LRU = 2'd0;
	localparam logic [1:0] POLICY_MRU = 2'd1;
	localparam logic [1:0] POLICY_LFU = 2'd2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_ACCESS = 1'b1;

	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_WAYS = 1'b1;

	typedef struct packed {
		logic hit;
		logic found;
		logic [WAY_IDX_W-1:0] way_used;
		logic [DATA_WIDTH-1:0] data_out;
		logic evicted;
		logic [ADDR_WIDTH-1:0] evicted_address;
	} result_t;

	typedef struct packed {
		logic valid;
		logic [ADDR_WIDTH-1:0] address;
		logic [DATA_WIDTH-1:0] data;
		logic [STAMP_W-1:0] last_use;
		logic [STAMP_W-1:0] use_count;
	} way_t;

endpackage

### design/assoc_cache_selectable_replacement.sv
// Fully associative cache with selectable replacement over a 128-word
// backing memory. Input words carry func, address and load_data under a
// valid/stall handshake; a load writes the backing memory and yields no
// result, an access yields exactly one result word.
// An accepted access reads the backing memory (a synchronous RAM with a
// registered read port); in the next cycle the way tags are compared, a
// victim is picked over the enabled ways and, on a hit or for a loaded
// word, the way is written back. The result word is registered from that
// compare cycle. The input stalls during the compare cycle and while a
// result word waits, so an access holds the input until its result is taken,
// while loads can follow one per cycle when no access is in flight. A stalled
// receiver holds the result register, and the block accepts no new word, load or access, until the result is taken.
// Reset clears way valid bits, stamps, counts, presence bits, the access
// clock (to one) and the registers (least recently used, eight ways).
// Configuration writes go through the plain write port at any idle time.
module assoc_cache_selectable_replacement (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [3:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [6:0] address,
	input logic signed [31:0] load_data,
	output logic out_valid,
	input logic out_stall,
	output logic hit,
	output logic found,
	output logic [2:0] way_used,
	output logic signed [31:0] data_out,
	output logic evicted,
	output logic [6:0] evicted_address
);

	logic [1:0] policy_q;
	logic [3:0] nways_q;
	logic [acsr_pkg::STAMP_W-1:0] clock_q;
	logic [acsr_pkg::MEM_WORDS-1:0] present_q;
	logic busy_s1, present_s1;
	logic [acsr_pkg::ADDR_WIDTH-1:0] addr_s1;
	logic [acsr_pkg::DATA_WIDTH-1:0] mem_rdata;
	acsr_pkg::way_t ways [acsr_pkg::WAYS];
	acsr_pkg::result_t res_q, res_d;
	logic accept, upd;
	logic [acsr_pkg::WAY_IDX_W-1:0] upd_way;
	acsr_pkg::way_t upd_entry;

	assign in_stall = busy_s1 || out_valid;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= acsr_pkg::POLICY_LRU;
			nways_q <= 4'd8;
		end else if (cfg_we) begin
			if (cfg_index == acsr_pkg::CFG_POLICY) policy_q <= cfg_data[1:0];
			else nways_q <= cfg_data;
		end
	end

	acsr_ram #(.WIDTH(acsr_pkg::DATA_WIDTH), .DEPTH(acsr_pkg::MEM_WORDS)) u_mem (
		.clk(clk),
		.we(accept && func == acsr_pkg::FUNC_LOAD),
		.waddr(address),
		.wdata(load_data),
		.raddr(address),
		.rdata(mem_rdata)
	);

	acsr_ways u_ways (
		.clk(clk), .arst_n(arst_n), .upd(upd), .upd_way(upd_way),
		.upd_entry(upd_entry), .ways(ways)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			busy_s1 <= 1'b0;
			present_s1 <= 1'b0;
			addr_s1 <= '0;
			clock_q <= 32'd1;
			out_valid <= 1'b0;
			res_q <= '0;
		end else begin
			if (accept && func == acsr_pkg::FUNC_LOAD) present_q[address] <= 1'b1;
			busy_s1 <= accept && func == acsr_pkg::FUNC_ACCESS;
			if (accept) begin
				addr_s1 <= address;
				present_s1 <= present_q[address];
			end
			if (busy_s1) begin
				res_q <= res_d;
				out_valid <= 1'b1;
				if (clock_q != '1) clock_q <= clock_q + 32'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		logic [3:0] n;
		logic is_hit, have_empty;
		logic [acsr_pkg::WAY_IDX_W-1:0] hw, ew, vw;
		logic better;
		n = nways_q == 4'd0 ? 4'd1 : (nways_q > 4'd8 ? 4'd8 : nways_q);
		is_hit = 1'b0; have_empty = 1'b0; hw = '0; ew = '0; vw = '0;
		for (int w = acsr_pkg::WAYS - 1; w >= 0; w--) begin
			if (4'(w) < n) begin
				if (ways[w].valid && ways[w].address == addr_s1) begin
					is_hit = 1'b1; hw = 3'(w);
				end
				if (!ways[w].valid) begin
					have_empty = 1'b1; ew = 3'(w);
				end
			end
		end
		for (int w = 1; w < acsr_pkg::WAYS; w++) begin
			case (policy_q)
				acsr_pkg::POLICY_LRU: better = ways[w].last_use < ways[vw].last_use;
				acsr_pkg::POLICY_MRU: better = ways[w].last_use > ways[vw].last_use;
				default: better = ways[w].use_count < ways[vw].use_count;
			endcase
			if (4'(w) < n && better) vw = 3'(w);
		end
		res_d = '0;
		upd = 1'b0;
		upd_way = '0;
		upd_entry = ways[0];
		if (busy_s1) begin
			if (is_hit) begin
				upd = 1'b1;
				upd_way = hw;
				upd_entry = ways[hw];
				upd_entry.last_use = clock_q;
				if (ways[hw].use_count != '1) upd_entry.use_count = ways[hw].use_count + 32'd1;
				res_d.hit = 1'b1;
				res_d.found = 1'b1;
				res_d.way_used = hw;
				res_d.data_out = ways[hw].data;
			end else if (present_s1) begin
				upd = 1'b1;
				upd_way = have_empty ? ew : vw;
				if (!have_empty) begin
					res_d.evicted = 1'b1;
					res_d.evicted_address = ways[vw].address;
				end
				upd_entry.valid = 1'b1;
				upd_entry.address = addr_s1;
				upd_entry.data = mem_rdata;
				upd_entry.last_use = clock_q;
				upd_entry.use_count = 32'd1;
				res_d.found = 1'b1;
				res_d.way_used = upd_way;
				res_d.data_out = mem_rdata;
			end
		end
	end

	assign hit = res_q.hit;
	assign found = res_q.found;
	assign way_used = res_q.way_used;
	assign data_out = res_q.data_out;
	assign evicted = res_q.evicted;
	assign evicted_address = res_q.evicted_address;

endmodule

### design/acsr_ram.sv
module acsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/acsr_ways.sv
module acsr_ways (
	input logic clk,
	input logic arst_n,
	input logic upd,
	input logic [acsr_pkg::WAY_IDX_W-1:0] upd_way,
	input acsr_pkg::way_t upd_entry,
	output acsr_pkg::way_t ways [acsr_pkg::WAYS]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acsr_pkg::WAYS; i++) begin
				ways[i].valid <= 1'b0;
				ways[i].last_use <= '0;
				ways[i].use_count <= '0;
				ways[i].address <= '0;
				ways[i].data <= '0;
			end
		end else if (upd) begin
			ways[upd_way] <= upd_entry;
		end
	end

endmodule

### design/acsr_checker.sv
module acsr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit,
	input logic found,
	input logic [2:0] way_used,
	input logic signed [31:0] data_out,
	input logic evicted,
	input logic [6:0] evicted_address
);

	a_hit_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> found) else $error("hit without found");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> way_used == 3'd0 && data_out == 32'sd0 && !evicted
			&& evicted_address == 7'd0)
		else $error("not found result not zero");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> !hit) else $error("eviction on hit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out))
		else $error("stalled result changed");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result waits");

endmodule

bind assoc_cache_selectable_replacement acsr_checker u_acsr_checker (.*);

### sim/assoc_cache_selectable_replacement_tb.sv
module assoc_cache_selectable_replacement_tb;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = acsr_pkg::FUNC_LOAD;
	logic [6:0] address = '0;
	logic signed [31:0] load_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic found;
	logic [2:0] way_used;
	logic signed [31:0] data_out;
	logic evicted;
	logic [6:0] evicted_address;

	assoc_cache_selectable_replacement dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the cache and backing memory.
	logic [31:0] mem_word [acsr_pkg::MEM_WORDS];
	logic mem_present [acsr_pkg::MEM_WORDS];
	acsr_pkg::way_t ways [acsr_pkg::WAYS];
	logic [31:0] access_clock;
	logic [1:0] policy;
	logic [3:0] ways_enabled;

	acsr_pkg::result_t expected_results[$];
	int mismatches = 0;
	int idle_pct = 27;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_off = 0;
	logic [6:0] addr_span = 7'd127;

	task automatic predict_word(input logic f, input logic [6:0] a, input logic [31:0] d);
		acsr_pkg::result_t r;
		int n;
		int slot;
		int best;
		logic is_hit;
		logic have_empty;
		if (f == acsr_pkg::FUNC_LOAD) begin
			mem_word[a] = d;
			mem_present[a] = 1'b1;
			return;
		end
		r = '0;
		n = (ways_enabled < 4'd1) ? 1
			: ((int'(ways_enabled) > acsr_pkg::WAYS) ? acsr_pkg::WAYS : int'(ways_enabled));
		is_hit = 1'b0;
		slot = 0;
		for (int w = 0; w < n; w++) begin
			if (!is_hit && ways[w].valid && ways[w].address == a) begin
				is_hit = 1'b1;
				slot = w;
			end
		end
		if (is_hit) begin
			ways[slot].last_use = access_clock;
			if (ways[slot].use_count != '1) ways[slot].use_count++;
			r.hit = 1'b1;
			r.found = 1'b1;
			r.way_used = 3'(slot);
			r.data_out = ways[slot].data;
		end else if (mem_present[a]) begin
			have_empty = 1'b0;
			for (int w = 0; w < n; w++) begin
				if (!have_empty && !ways[w].valid) begin
					have_empty = 1'b1;
					slot = w;
				end
			end
			if (!have_empty) begin
				best = 0;
				for (int w = 1; w < n; w++) begin
					if (policy == acsr_pkg::POLICY_LRU) begin
						if (ways[w].last_use < ways[best].last_use) best = w;
					end else if (policy == acsr_pkg::POLICY_MRU) begin
						if (ways[w].last_use > ways[best].last_use) best = w;
					end else if (ways[w].use_count < ways[best].use_count) begin
						best = w;
					end
				end
				slot = best;
				r.evicted = 1'b1;
				r.evicted_address = ways[slot].address;
			end
			ways[slot].valid = 1'b1;
			ways[slot].address = a;
			ways[slot].data = mem_word[a];
			ways[slot].last_use = access_clock;
			ways[slot].use_count = 32'd1;
			r.found = 1'b1;
			r.way_used = 3'(slot);
			r.data_out = mem_word[a];
		end
		if (access_clock != '1) access_clock++;
		expected_results.push_back(r);
	endtask

	task automatic send_word(input logic f, input logic [6:0] a, input logic [31:0] d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		load_data <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(f, a, d);
		@(negedge clk);
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_results.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == acsr_pkg::CFG_POLICY) policy = val[1:0];
		else ways_enabled = val;
	endtask

	always @(posedge clk) begin
		acsr_pkg::result_t want;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word");
			end else begin
				want = expected_results.pop_front();
				if (hit !== want.hit || found !== want.found || way_used !== want.way_used
						|| data_out !== want.data_out || evicted !== want.evicted
						|| evicted_address !== want.evicted_address) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %b %b %0d %h %b %0d got %b %b %0d %h %b %0d",
							want.hit, want.found, want.way_used, want.data_out, want.evicted,
							want.evicted_address, hit, found, way_used, data_out, evicted,
							evicted_address);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_off <= 200;
			out_stall <= 1'b1;
		end else if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	task automatic random_traffic(input int count);
		logic [6:0] a;
		for (int i = 0; i < count; i++) begin
			a = 7'($urandom_range(addr_span));
			if ($urandom_range(3) == 0) send_word(acsr_pkg::FUNC_LOAD, a, $urandom);
			else send_word(acsr_pkg::FUNC_ACCESS, a, 32'd0);
		end
	endtask

	task automatic test_directed;
		send_word(acsr_pkg::FUNC_ACCESS, 7'd0, 32'd0);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd127, 32'd0);
		send_word(acsr_pkg::FUNC_LOAD, 7'd0, 32'h0000_0000);
		send_word(acsr_pkg::FUNC_LOAD, 7'd127, 32'hFFFF_FFFF);
		send_word(acsr_pkg::FUNC_LOAD, 7'd85, 32'h8000_0000);
		send_word(acsr_pkg::FUNC_LOAD, 7'd42, 32'h7FFF_FFFF);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd0, 32'd0);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd127, 32'd0);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd127, 32'd0);
		send_word(acsr_pkg::FUNC_LOAD, 7'd127, 32'h5555_AAAA);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd127, 32'd0);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd85, 32'd0);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd42, 32'd0);
		send_word(acsr_pkg::FUNC_ACCESS, 7'd3, 32'd0);
	endtask

	task automatic test_policies;
		logic [3:0] way_counts [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
		for (int p = 0; p < 4; p++) begin
			for (int k = 0; k < 6; k++) begin
				write_reg(acsr_pkg::CFG_POLICY, 4'(p));
				write_reg(acsr_pkg::CFG_WAYS, way_counts[k]);
				addr_span = (k % 2) ? 7'd127 : 7'd15;
				random_traffic(30);
			end
		end
	endtask

	task automatic test_no_idle;
		idle_pct = 0;
		random_traffic(120);
		idle_pct = 27;
	endtask

	task automatic test_backpressure;
		hold_reqs++;
		random_traffic(40);
		drain();
		random_traffic(40);
	endtask

	initial begin
		foreach (mem_present[i]) mem_present[i] = 1'b0;
		foreach (ways[i]) ways[i] = '0;
		access_clock = 1;
		policy = acsr_pkg::POLICY_LRU;
		ways_enabled = 4'd8;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_policies();
		test_no_idle();
		test_backpressure();
		write_reg(acsr_pkg::CFG_WAYS, 4'd8);
		write_reg(acsr_pkg::CFG_POLICY, 4'(acsr_pkg::POLICY_LFU));
		addr_span = 7'd127;
		random_traffic(120);
		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

endmodule
